@@ src/mv2p_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes, checksum step and extra-byte table for the MAVLink v2 parser.
package mv2p_pkg;

   localparam int HEADER_BYTES    = 10;
   localparam int SIGNATURE_BYTES = 13;

   localparam logic [7:0] START_BYTE  = 8'hFD;
   localparam int         SIGNED_FLAG_BIT = 0;

   // parser phase codes
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_CHECK   = 3'd3;
   localparam logic [2:0] PH_SIG     = 3'd4;

   // byte kinds
   localparam logic [2:0] KIND_DROP      = 3'd0;
   localparam logic [2:0] KIND_HEADER    = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD   = 3'd2;
   localparam logic [2:0] KIND_CHECKSUM  = 3'd3;
   localparam logic [2:0] KIND_SIGNATURE = 3'd4;

   // frame events
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_ACCEPT  = 2'd1;
   localparam logic [1:0] EV_BAD_LOW = 2'd2;
   localparam logic [1:0] EV_BAD_HI  = 2'd3;

   // header byte positions
   localparam logic [7:0] HB_LENGTH  = 8'd1;
   localparam logic [7:0] HB_INCOMPAT = 8'd2;
   localparam logic [7:0] HB_SEQ     = 8'd4;
   localparam logic [7:0] HB_SYS     = 8'd5;
   localparam logic [7:0] HB_COMP    = 8'd6;
   localparam logic [7:0] HB_MSG0    = 8'd7;
   localparam logic [7:0] HB_MSG1    = 8'd8;
   localparam logic [7:0] HB_MSG2    = 8'd9;

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  count;
      logic [15:0] csum;
      logic [7:0]  length;
      logic        signed_f;
      logic [7:0]  seq;
      logic [7:0]  sys;
      logic [7:0]  comp;
      logic [23:0] msg_id;
   } state_type;

   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [1:0]  frame_event;
      logic [7:0]  payload_length;
      logic [23:0] message_id;
      logic [7:0]  system_id;
      logic [7:0]  component_id;
      logic [7:0]  sequence_number;
      logic        signed_frame;
      logic [15:0] computed_checksum;
   } rsp_type;

   // one byte of the running checksum, ck_a in bits 7..0
   function automatic logic [15:0] sum_byte(input logic [15:0] sum, input logic [7:0] b);
      logic [7:0] t;
      logic [7:0] hi;
      logic [7:0] lo;
      t  = b ^ sum[7:0];
      lo = sum[15:8];
      hi = t;
      t  = {t[3:0], t[7:4]};
      hi = hi ^ t;
      t  = {1'b0, t[3:0], 3'b000};
      hi = hi ^ t;
      hi = hi ^ {4'h0, hi[7:4]};
      return {hi, lo};
   endfunction

   // per-message extra byte, zero for unknown ids
   function automatic logic [7:0] extra_for(input logic [23:0] id);
      logic [7:0] v;
      case (id)
         24'd0:   v = 8'd50;
         24'd1:   v = 8'd124;
         24'd24:  v = 8'd137;
         24'd30:  v = 8'd147;
         24'd33:  v = 8'd104;
         24'd35:  v = 8'd246;
         24'd39:  v = 8'd254;
         24'd42:  v = 8'd28;
         24'd44:  v = 8'd221;
         24'd76:  v = 8'd152;
         24'd77:  v = 8'd143;
         24'd147: v = 8'd154;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

@@ src/mv2p_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and parsed results.
interface mv2p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mv2p_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_kind;
   logic [7:0]  data_byte;
   logic [7:0]  byte_index;
   logic [1:0]  frame_event;
   logic [7:0]  payload_length;
   logic [23:0] message_id;
   logic [7:0]  system_id;
   logic [7:0]  component_id;
   logic [7:0]  sequence_number;
   logic        signed_frame;
   logic [15:0] computed_checksum;

   modport source (output valid, output byte_kind, output data_byte, output byte_index,
                   output frame_event, output payload_length, output message_id,
                   output system_id, output component_id, output sequence_number,
                   output signed_frame, output computed_checksum, input ready);
   modport sink   (input valid, input byte_kind, input data_byte, input byte_index,
                   input frame_event, input payload_length, input message_id,
                   input system_id, input component_id, input sequence_number,
                   input signed_frame, input computed_checksum, output ready);
endinterface

@@ src/mv2p_in_stage.sv @@
`timescale 1ns / 1ps
// Input register for received bytes.
module mv2p_in_stage (
   input  logic       clock,
   input  logic       reset,
   mv2p_req_if.sink   req_bus,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       load;

   assign req_bus.ready = !valid_ff || take;
   assign load          = req_bus.valid && req_bus.ready;
   assign valid_in      = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_bus.rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

@@ src/mv2p_step.sv @@
`timescale 1ns / 1ps
// Per-byte parser step: next state and result from current state and one byte.
module mv2p_step #(
   parameter int SIGNATURE_BYTES = mv2p_pkg::SIGNATURE_BYTES
) (
   input  mv2p_pkg::state_type cur,
   input  logic [7:0]          rx_byte,
   output mv2p_pkg::state_type nxt,
   output mv2p_pkg::rsp_type   res
);

   logic [7:0]  cnt_inc;
   logic [15:0] fin_cur;
   logic [15:0] fin_nxt;
   logic        finish;
   logic [2:0]  kind;
   logic [7:0]  idx;
   logic [1:0]  ev;
   mv2p_pkg::state_type upd;

   assign cnt_inc = cur.count + 8'd1;
   assign fin_cur = mv2p_pkg::sum_byte(cur.csum, mv2p_pkg::extra_for(cur.msg_id));

   always_comb begin
      upd    = cur;
      kind   = mv2p_pkg::KIND_DROP;
      idx    = 8'd0;
      ev     = mv2p_pkg::EV_NONE;
      finish = 1'b0;
      case (cur.phase)
         mv2p_pkg::PH_IDLE: begin
            if (rx_byte == mv2p_pkg::START_BYTE) begin
               kind         = mv2p_pkg::KIND_HEADER;
               upd.csum     = mv2p_pkg::sum_byte(16'h0000, rx_byte);
               upd.signed_f = 1'b0;
               upd.count    = 8'd1;
               upd.phase    = mv2p_pkg::PH_HEADER;
            end
         end
         mv2p_pkg::PH_HEADER: begin
            kind     = mv2p_pkg::KIND_HEADER;
            idx      = cur.count;
            upd.csum = mv2p_pkg::sum_byte(cur.csum, rx_byte);
            case (cur.count)
               mv2p_pkg::HB_LENGTH:   upd.length   = rx_byte;
               mv2p_pkg::HB_INCOMPAT: upd.signed_f = rx_byte[mv2p_pkg::SIGNED_FLAG_BIT];
               mv2p_pkg::HB_SEQ:      upd.seq      = rx_byte;
               mv2p_pkg::HB_SYS:      upd.sys      = rx_byte;
               mv2p_pkg::HB_COMP:     upd.comp     = rx_byte;
               mv2p_pkg::HB_MSG0:     upd.msg_id[7:0]   = rx_byte;
               mv2p_pkg::HB_MSG1:     upd.msg_id[15:8]  = rx_byte;
               mv2p_pkg::HB_MSG2:     upd.msg_id[23:16] = rx_byte;
               default: ;
            endcase
            if (cnt_inc >= 8'(mv2p_pkg::HEADER_BYTES)) begin
               upd.count = 8'd0;
               // empty payload skips straight to the checksum
               upd.phase = (upd.length == 8'd0) ? mv2p_pkg::PH_CHECK : mv2p_pkg::PH_PAYLOAD;
            end else begin
               upd.count = cnt_inc;
            end
         end
         mv2p_pkg::PH_PAYLOAD: begin
            kind     = mv2p_pkg::KIND_PAYLOAD;
            idx      = cur.count;
            upd.csum = mv2p_pkg::sum_byte(cur.csum, rx_byte);
            if (cnt_inc >= cur.length) begin
               upd.count = 8'd0;
               upd.phase = mv2p_pkg::PH_CHECK;
            end else begin
               upd.count = cnt_inc;
            end
         end
         mv2p_pkg::PH_CHECK: begin
            kind = mv2p_pkg::KIND_CHECKSUM;
            idx  = cur.count;
            if (cur.count == 8'd0) begin
               if (rx_byte != fin_cur[7:0]) begin
                  ev     = mv2p_pkg::EV_BAD_LOW;
                  finish = 1'b1;
               end else begin
                  upd.count = 8'd1;
               end
            end else if (rx_byte != fin_cur[15:8]) begin
               ev     = mv2p_pkg::EV_BAD_HI;
               finish = 1'b1;
            end else if (cur.signed_f) begin
               upd.count = 8'd0;
               upd.phase = mv2p_pkg::PH_SIG;
            end else begin
               ev     = mv2p_pkg::EV_ACCEPT;
               finish = 1'b1;
            end
         end
         mv2p_pkg::PH_SIG: begin
            kind      = mv2p_pkg::KIND_SIGNATURE;
            idx       = cur.count;
            upd.count = cnt_inc;
            if (cnt_inc >= 8'(SIGNATURE_BYTES)) begin
               ev     = mv2p_pkg::EV_ACCEPT;
               finish = 1'b1;
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase
   end

   assign fin_nxt = mv2p_pkg::sum_byte(upd.csum, mv2p_pkg::extra_for(upd.msg_id));

   always_comb begin
      nxt = upd;
      if (finish) begin
         nxt.phase    = mv2p_pkg::PH_IDLE;
         nxt.count    = 8'd0;
         nxt.csum     = 16'h0000;
         nxt.signed_f = 1'b0;
      end
   end

   always_comb begin
      res.byte_kind         = kind;
      res.data_byte         = rx_byte;
      res.byte_index        = idx;
      res.frame_event       = ev;
      res.payload_length    = upd.length;
      res.message_id        = upd.msg_id;
      res.system_id         = upd.sys;
      res.component_id      = upd.comp;
      res.sequence_number   = upd.seq;
      res.signed_frame      = upd.signed_f;   // flag of the frame this byte belongs to
      res.computed_checksum = fin_nxt;
   end

endmodule

@@ src/mavlink_v2_frame_parser.sv @@
`timescale 1ns / 1ps
// Top level of the MAVLink v2 byte-stream frame parser.
//
//   channel   dir  beat payload                               accepted when
//   req_bus   in   rx_byte                                     valid & ready
//   rsp_bus   out  kind, byte, index, event, header, checksum  valid & ready
//
// One result beat per received byte, one beat per cycle sustained while rsp_bus is ready.
// A byte passes the input register, then one step of parser logic into
// the result register. The checksum step and the 12-entry extra-byte lookup
// are the longest path. Synchronous reset returns the parser to idle with all
// header fields cleared. A stalled result holds; the input register still
// fills, so a byte waits in each stage and req_bus.ready drops only then.
module mavlink_v2_frame_parser #(
   parameter int SIGNATURE_BYTES = mv2p_pkg::SIGNATURE_BYTES
) (
   input logic        clock,
   input logic        reset,
   mv2p_req_if.sink   req_bus,
   mv2p_rsp_if.source rsp_bus
);

   logic                in_valid;
   logic [7:0]          in_byte;
   logic                advance;
   logic                fire;

   mv2p_pkg::state_type state_ff;
   mv2p_pkg::state_type state_in;
   mv2p_pkg::rsp_type   result_in;
   mv2p_pkg::rsp_type   result_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   // result register frees up when empty or being taken
   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign fire    = in_valid && advance;

   mv2p_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (advance),
      .byte_valid (in_valid),
      .byte_data  (in_byte)
   );

   mv2p_step #(
      .SIGNATURE_BYTES (SIGNATURE_BYTES)
   ) u_step (
      .cur     (state_ff),
      .rx_byte (in_byte),
      .nxt     (state_in),
      .res     (result_in)
   );

   assign rsp_valid_in = advance ? in_valid : rsp_valid_ff;

   // parser state advances once per byte handed to the result register;
   // all-zero state is the idle phase with every field cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.byte_kind         = result_ff.byte_kind;
   assign rsp_bus.data_byte         = result_ff.data_byte;
   assign rsp_bus.byte_index        = result_ff.byte_index;
   assign rsp_bus.frame_event       = result_ff.frame_event;
   assign rsp_bus.payload_length    = result_ff.payload_length;
   assign rsp_bus.message_id        = result_ff.message_id;
   assign rsp_bus.system_id         = result_ff.system_id;
   assign rsp_bus.component_id      = result_ff.component_id;
   assign rsp_bus.sequence_number   = result_ff.sequence_number;
   assign rsp_bus.signed_frame      = result_ff.signed_frame;
   assign rsp_bus.computed_checksum = result_ff.computed_checksum;

`ifndef NO_ASSERTIONS
   // a new result beat only appears after a byte sat in the input register
   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid))
      else $error("result beat without an input byte");

   // idle always means count, checksum and signature flag were cleared
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == mv2p_pkg::PH_IDLE) |->
         (state_ff.count == 8'd0 && state_ff.csum == 16'h0000 && !state_ff.signed_f))
      else $error("idle phase with stale frame state");

   // frames are accepted only on a checksum or signature byte
   a_accept_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.frame_event == mv2p_pkg::EV_ACCEPT) |->
         (result_ff.byte_kind == mv2p_pkg::KIND_CHECKSUM ||
          result_ff.byte_kind == mv2p_pkg::KIND_SIGNATURE))
      else $error("frame accepted on wrong byte kind");
`endif

endmodule
